// ===== rtl/mesh_flood_duplicate_filter_top_macros.svh =====
// Assertion helpers for the duplicate filter. Each helper checks one
// implication, sampled on the rising clock edge and held off during reset.
`ifndef MESH_FLOOD_DUPLICATE_FILTER_TOP_MACROS_SVH
`define MESH_FLOOD_DUPLICATE_FILTER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
`define MFDF_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
`define MFDF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MFDF_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg)
`define MFDF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ===== rtl/mfdf_pkg.sv =====
package mfdf_pkg;

    localparam int CACHE_DEPTH_DEF = 32;

    localparam int ID_W   = 32;
    localparam int MAC_W  = 48;
    localparam int BYTE_W = 8;
    localparam int CNT_W  = 32;
    localparam int VERD_W = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 48;

    localparam logic [MAC_W-1:0] BCAST_ADDR = {MAC_W{1'b1}};

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MY_MAC     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PROTO_VER  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EMERG_TYPE = 2'd2;

    localparam logic [BYTE_W-1:0] PROTO_VER_RST = 8'd1;

    // Verdict codes.
    localparam logic [VERD_W-1:0] VERD_ACCEPT   = 3'd0;
    localparam logic [VERD_W-1:0] VERD_BAD_VER  = 3'd1;
    localparam logic [VERD_W-1:0] VERD_DUP      = 3'd2;
    localparam logic [VERD_W-1:0] VERD_AUTH     = 3'd3;
    localparam logic [VERD_W-1:0] VERD_REPLAY   = 3'd4;
    localparam logic [VERD_W-1:0] VERD_RECORDED = 3'd5;

    // Command word from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic scan;
        logic finish;
    } dp_cmd_t;

    // Status word from the datapath to the controller.
    typedef struct packed {
        logic scan_last;
    } dp_status_t;

endpackage

// ===== rtl/mfdf_ctrl.sv =====
module mfdf_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  mfdf_pkg::dp_status_t status,
    output mfdf_pkg::dp_cmd_t    cmd,
    output logic                 busy,
    output logic                 done
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_FIN  = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (status.scan_last)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_FIN);
        end
    end

    assign cmd.load   = (state_reg == S_IDLE) && start;
    assign cmd.scan   = (state_reg == S_SCAN);
    assign cmd.finish = (state_reg == S_FIN);
    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;

endmodule

// ===== rtl/mfdf_dp.sv =====
module mfdf_dp
#(
    parameter int CACHE_DEPTH = mfdf_pkg::CACHE_DEPTH_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  mfdf_pkg::dp_cmd_t                   cmd,
    output mfdf_pkg::dp_status_t                status,
    input  logic                                cfg_wr_en,
    input  logic [mfdf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mfdf_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                command,
    input  logic [mfdf_pkg::BYTE_W-1:0]         version,
    input  logic [mfdf_pkg::ID_W-1:0]           message_id,
    input  logic [mfdf_pkg::BYTE_W-1:0]         msg_type,
    input  logic [mfdf_pkg::BYTE_W-1:0]         ttl,
    input  logic [mfdf_pkg::BYTE_W-1:0]         hop_count,
    input  logic [mfdf_pkg::MAC_W-1:0]          origin_mac,
    input  logic [mfdf_pkg::MAC_W-1:0]          dest_mac,
    input  logic                                auth_ok,
    input  logic                                replay_ok,
    output logic [mfdf_pkg::VERD_W-1:0]         verdict,
    output logic                                for_us,
    output logic                                relay,
    output logic [mfdf_pkg::BYTE_W-1:0]         relay_ttl,
    output logic [mfdf_pkg::BYTE_W-1:0]         relay_hops,
    output logic [mfdf_pkg::CNT_W-1:0]          dropped_total,
    output logic [mfdf_pkg::CNT_W-1:0]          received_total
);

    localparam int AW = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
    localparam int FW = $clog2(CACHE_DEPTH + 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(CACHE_DEPTH - 1);
    localparam logic [FW-1:0] FULL_CNT  = FW'(CACHE_DEPTH);

    // Configuration registers.
    logic [mfdf_pkg::MAC_W-1:0]  my_mac_reg;
    logic [mfdf_pkg::BYTE_W-1:0] proto_ver_reg;
    logic [mfdf_pkg::BYTE_W-1:0] emerg_type_reg;

    // Captured header word.
    logic                        command_reg;
    logic [mfdf_pkg::BYTE_W-1:0] version_reg;
    logic [mfdf_pkg::ID_W-1:0]   id_reg;
    logic [mfdf_pkg::BYTE_W-1:0] type_reg;
    logic [mfdf_pkg::BYTE_W-1:0] ttl_reg;
    logic [mfdf_pkg::BYTE_W-1:0] hops_reg;
    logic [mfdf_pkg::MAC_W-1:0]  origin_reg;
    logic [mfdf_pkg::MAC_W-1:0]  dest_reg;
    logic                        auth_reg;
    logic                        replay_reg;

    // Id cache and its scan.
    logic [mfdf_pkg::ID_W-1:0] cache_mem [CACHE_DEPTH];
    logic [mfdf_pkg::ID_W-1:0] rd_data_reg;
    logic [AW-1:0]             addr_reg;
    logic [AW-1:0]             rd_idx_reg;
    logic                      rd_vld_reg;
    logic                      hit_reg;
    logic [AW-1:0]             slot_reg;
    logic [FW-1:0]             fill_reg;

    logic [mfdf_pkg::CNT_W-1:0] drop_cnt_reg;
    logic [mfdf_pkg::CNT_W-1:0] acc_cnt_reg;

    logic [mfdf_pkg::VERD_W-1:0] verdict_reg;
    logic [mfdf_pkg::VERD_W-1:0] verdict_next;
    logic                        for_us_reg;
    logic                        relay_reg;
    logic                        relay_next;
    logic [mfdf_pkg::BYTE_W-1:0] relay_ttl_reg;
    logic [mfdf_pkg::BYTE_W-1:0] relay_hops_reg;

    logic [mfdf_pkg::ID_W-1:0] entry_val;
    logic                      hit_now;
    logic                      is_dup;
    logic                      dest_bcast;
    logic                      dest_me;
    logic                      do_write;
    logic                      do_drop;
    logic                      do_accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            my_mac_reg     <= '0;
            proto_ver_reg  <= mfdf_pkg::PROTO_VER_RST;
            emerg_type_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                mfdf_pkg::REG_MY_MAC:     my_mac_reg     <= cfg_data;
                mfdf_pkg::REG_PROTO_VER:  proto_ver_reg  <= cfg_data[mfdf_pkg::BYTE_W-1:0];
                mfdf_pkg::REG_EMERG_TYPE: emerg_type_reg <= cfg_data[mfdf_pkg::BYTE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            command_reg <= command;
            version_reg <= version;
            id_reg      <= message_id;
            type_reg    <= msg_type;
            ttl_reg     <= ttl;
            hops_reg    <= hop_count;
            origin_reg  <= origin_mac;
            dest_reg    <= dest_mac;
            auth_reg    <= auth_ok;
            replay_reg  <= replay_ok;
        end
    end

    // Entries past the fill count were never written and read as zero.
    assign entry_val = (FW'(rd_idx_reg) < fill_reg) ? rd_data_reg : '0;
    assign hit_now   = rd_vld_reg && (entry_val == id_reg);
    assign is_dup    = hit_reg || hit_now;

    assign status.scan_last = cmd.scan && (addr_reg == LAST_ADDR);

    assign dest_bcast = (dest_reg == mfdf_pkg::BCAST_ADDR);
    assign dest_me    = (dest_reg == my_mac_reg);

    always_comb
    begin
        verdict_next = mfdf_pkg::VERD_ACCEPT;
        do_drop      = 1'b0;
        do_accept    = 1'b0;
        if (command_reg)
        begin
            verdict_next = mfdf_pkg::VERD_RECORDED;
        end
        else if (version_reg != proto_ver_reg)
        begin
            verdict_next = mfdf_pkg::VERD_BAD_VER;
            do_drop      = 1'b1;
        end
        else if (is_dup)
        begin
            verdict_next = mfdf_pkg::VERD_DUP;
        end
        else if (!auth_reg)
        begin
            verdict_next = mfdf_pkg::VERD_AUTH;
            do_drop      = 1'b1;
        end
        else if (!replay_reg)
        begin
            verdict_next = mfdf_pkg::VERD_REPLAY;
            do_drop      = 1'b1;
        end
        else
        begin
            do_accept = 1'b1;
        end
    end

    assign relay_next = do_accept && (origin_reg != my_mac_reg) && (ttl_reg > 8'd1)
                        && ((type_reg == emerg_type_reg) || dest_bcast || !dest_me);
    assign do_write   = cmd.finish && (command_reg || do_accept);

    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            cache_mem[slot_reg] <= id_reg;
        end
        rd_data_reg <= cache_mem[addr_reg];
        rd_idx_reg  <= addr_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg     <= '0;
            rd_vld_reg   <= 1'b0;
            hit_reg      <= 1'b0;
            slot_reg     <= '0;
            fill_reg     <= '0;
            drop_cnt_reg <= '0;
            acc_cnt_reg  <= '0;
        end
        else
        begin
            rd_vld_reg <= cmd.scan;
            if (cmd.load)
            begin
                addr_reg <= '0;
                hit_reg  <= 1'b0;
            end
            else if (cmd.scan)
            begin
                addr_reg <= (addr_reg == LAST_ADDR) ? '0 : addr_reg + 1'b1;
                hit_reg  <= is_dup;
            end
            if (do_write)
            begin
                slot_reg <= (slot_reg == LAST_ADDR) ? '0 : slot_reg + 1'b1;
                if (fill_reg != FULL_CNT)
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end
            if (cmd.finish && do_drop)
            begin
                drop_cnt_reg <= drop_cnt_reg + 1'b1;
            end
            if (cmd.finish && do_accept)
            begin
                acc_cnt_reg <= acc_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            verdict_reg    <= verdict_next;
            for_us_reg     <= do_accept && (dest_me || dest_bcast);
            relay_reg      <= relay_next;
            relay_ttl_reg  <= relay_next ? ttl_reg - 1'b1 : '0;
            relay_hops_reg <= relay_next ? hops_reg + 1'b1 : '0;
        end
    end

    assign verdict        = verdict_reg;
    assign for_us         = for_us_reg;
    assign relay          = relay_reg;
    assign relay_ttl      = relay_ttl_reg;
    assign relay_hops     = relay_hops_reg;
    assign dropped_total  = drop_cnt_reg;
    assign received_total = acc_cnt_reg;

endmodule

// ===== rtl/mesh_flood_duplicate_filter_top.sv =====
// Header screen for a flooding mesh. Pulse start with a header word while busy
// is low; the block rejects wrong versions, drops ids already held in a ring
// cache of CACHE_DEPTH recent ids, drops packets that failed the outside
// authentication or replay checks, and for accepted packets records the id and
// decides on local delivery and relay. A record command only writes the id
// into the cache. A word is screened by a sweep of the whole cache before the
// next start can be taken: the cache sits in one memory whose single read port
// is swept one entry per cycle, busy stays high for that sweep and for a finish
// state that settles the verdict, and the next start is taken in the first idle
// cycle after that. The result word appears in the cycle in which busy falls,
// marked by done high for exactly one cycle; the receiver cannot hold it off,
// so it must take it in that cycle. A new start may be given in that same cycle.
// The drop and receive totals wrap and stay on their ports between results. The
// cache reads as all zero after reset without any clearing pass: a fill count
// marks which entries have been written, so id zero counts as seen until the
// ring has been overwritten. Configuration writes are taken at once and must
// only be made while idle.
`include "mesh_flood_duplicate_filter_top_macros.svh"

module mesh_flood_duplicate_filter_top
#(
    parameter int CACHE_DEPTH = mfdf_pkg::CACHE_DEPTH_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    output logic                                done,
    input  logic                                cfg_wr_en,
    input  logic [mfdf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mfdf_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                command,
    input  logic [mfdf_pkg::BYTE_W-1:0]         version,
    input  logic [mfdf_pkg::ID_W-1:0]           message_id,
    input  logic [mfdf_pkg::BYTE_W-1:0]         msg_type,
    input  logic [mfdf_pkg::BYTE_W-1:0]         ttl,
    input  logic [mfdf_pkg::BYTE_W-1:0]         hop_count,
    input  logic [mfdf_pkg::MAC_W-1:0]          origin_mac,
    input  logic [mfdf_pkg::MAC_W-1:0]          dest_mac,
    input  logic                                auth_ok,
    input  logic                                replay_ok,
    output logic [mfdf_pkg::VERD_W-1:0]         verdict,
    output logic                                for_us,
    output logic                                relay,
    output logic [mfdf_pkg::BYTE_W-1:0]         relay_ttl,
    output logic [mfdf_pkg::BYTE_W-1:0]         relay_hops,
    output logic [mfdf_pkg::CNT_W-1:0]          dropped_total,
    output logic [mfdf_pkg::CNT_W-1:0]          received_total
);

    // The controller sequences load, cache sweep and finish; the datapath
    // holds the configuration, the captured header, the cache and counters.
    mfdf_pkg::dp_cmd_t    dp_cmd;
    mfdf_pkg::dp_status_t dp_status;

    mfdf_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (dp_status),
        .cmd    (dp_cmd),
        .busy   (busy),
        .done   (done)
    );

    mfdf_dp
    #(
        .CACHE_DEPTH (CACHE_DEPTH)
    )
    u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (dp_cmd),
        .status         (dp_status),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .command        (command),
        .version        (version),
        .message_id     (message_id),
        .msg_type       (msg_type),
        .ttl            (ttl),
        .hop_count      (hop_count),
        .origin_mac     (origin_mac),
        .dest_mac       (dest_mac),
        .auth_ok        (auth_ok),
        .replay_ok      (replay_ok),
        .verdict        (verdict),
        .for_us         (for_us),
        .relay          (relay),
        .relay_ttl      (relay_ttl),
        .relay_hops     (relay_hops),
        .dropped_total  (dropped_total),
        .received_total (received_total)
    );

    // An accepted start always leads into the cache sweep.
    `MFDF_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy, "start did not raise busy")

    // A result is only shown once the block is ready for the next word.
    `MFDF_ASSERT_SAME(a_done_idle, clk, rst_n, done, !busy, "result shown while busy")

    // Only accepted packets may be delivered or relayed.
    `MFDF_ASSERT_SAME(a_reject_quiet, clk, rst_n,
        done && (verdict != mfdf_pkg::VERD_ACCEPT), !for_us && !relay,
        "rejected word marked for delivery or relay")

    // A relayed copy always keeps some hop budget.
    `MFDF_ASSERT_SAME(a_relay_ttl, clk, rst_n, done && relay, relay_ttl != 8'd0,
        "relay with zero ttl")

endmodule

// ===== verif/tb_mesh_flood_duplicate_filter_top.sv =====
module tb_mesh_flood_duplicate_filter_top;

    // The spare register index has no register behind it; writes to it must be dropped.
    localparam logic [mfdf_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    // One header word as it goes into the filter.
    typedef struct packed {
        logic                          cmd;
        logic [mfdf_pkg::BYTE_W-1:0]   ver;
        logic [mfdf_pkg::ID_W-1:0]     id;
        logic [mfdf_pkg::BYTE_W-1:0]   mtype;
        logic [mfdf_pkg::BYTE_W-1:0]   ttl;
        logic [mfdf_pkg::BYTE_W-1:0]   hops;
        logic [mfdf_pkg::MAC_W-1:0]    origin;
        logic [mfdf_pkg::MAC_W-1:0]    dest;
        logic                          auth;
        logic                          replay;
    } hdr_word_t;

    // One screening result as it comes out of the filter.
    typedef struct packed {
        logic [mfdf_pkg::VERD_W-1:0]   verdict;
        logic                          for_us;
        logic                          relay;
        logic [mfdf_pkg::BYTE_W-1:0]   relay_ttl;
        logic [mfdf_pkg::BYTE_W-1:0]   relay_hops;
        logic [mfdf_pkg::CNT_W-1:0]    dropped;
        logic [mfdf_pkg::CNT_W-1:0]    received;
    } screen_result_t;

    // A row of the directed table. The result is typed in only where it is
    // obvious; all other rows are checked against the screening predictor.
    typedef struct {
        hdr_word_t      word;
        bit             typed;
        screen_result_t want;
    } stim_row_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            start = 1'b0;
    logic                            busy;
    logic                            done;
    logic                            cfg_wr_en = 1'b0;
    logic [mfdf_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [mfdf_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                            command = 1'b0;
    logic [mfdf_pkg::BYTE_W-1:0]     version = '0;
    logic [mfdf_pkg::ID_W-1:0]       message_id = '0;
    logic [mfdf_pkg::BYTE_W-1:0]     msg_type = '0;
    logic [mfdf_pkg::BYTE_W-1:0]     ttl = '0;
    logic [mfdf_pkg::BYTE_W-1:0]     hop_count = '0;
    logic [mfdf_pkg::MAC_W-1:0]      origin_mac = '0;
    logic [mfdf_pkg::MAC_W-1:0]      dest_mac = '0;
    logic                            auth_ok = 1'b0;
    logic                            replay_ok = 1'b0;
    logic [mfdf_pkg::VERD_W-1:0]     verdict;
    logic                            for_us;
    logic                            relay;
    logic [mfdf_pkg::BYTE_W-1:0]     relay_ttl;
    logic [mfdf_pkg::BYTE_W-1:0]     relay_hops;
    logic [mfdf_pkg::CNT_W-1:0]      dropped_total;
    logic [mfdf_pkg::CNT_W-1:0]      received_total;

    // Shadow of the configuration registers, starting at their reset values.
    logic [mfdf_pkg::MAC_W-1:0]      node_mac = '0;
    logic [mfdf_pkg::BYTE_W-1:0]     want_version = mfdf_pkg::PROTO_VER_RST;
    logic [mfdf_pkg::BYTE_W-1:0]     urgent_type = '0;

    // Shadow of the id ring and the two totals.
    logic [mfdf_pkg::ID_W-1:0]       seen_ring [mfdf_pkg::CACHE_DEPTH_DEF];
    int unsigned                     ring_slot = 0;
    logic [mfdf_pkg::CNT_W-1:0]      drop_tally = '0;
    logic [mfdf_pkg::CNT_W-1:0]      accept_tally = '0;

    // Results owed by the filter, oldest first, and the ids sent lately.
    screen_result_t                  pending_verdicts [$];
    logic [mfdf_pkg::ID_W-1:0]       recent_ids [$];
    stim_row_t                       rows [$];
    screen_result_t                  head_r;
    bit                              fail_seen = 1'b0;

    mesh_flood_duplicate_filter_top dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .done           (done),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .command        (command),
        .version        (version),
        .message_id     (message_id),
        .msg_type       (msg_type),
        .ttl            (ttl),
        .hop_count      (hop_count),
        .origin_mac     (origin_mac),
        .dest_mac       (dest_mac),
        .auth_ok        (auth_ok),
        .replay_ok      (replay_ok),
        .verdict        (verdict),
        .for_us         (for_us),
        .relay          (relay),
        .relay_ttl      (relay_ttl),
        .relay_hops     (relay_hops),
        .dropped_total  (dropped_total),
        .received_total (received_total)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic hdr_word_t hdr(input logic c, input logic [7:0] v, input logic [31:0] i,
                                      input logic [7:0] mt, input logic [7:0] t,
                                      input logic [7:0] h, input logic [47:0] o,
                                      input logic [47:0] d, input logic a, input logic r);
        hdr_word_t w;
        w = '{cmd: c, ver: v, id: i, mtype: mt, ttl: t, hops: h, origin: o, dest: d,
              auth: a, replay: r};
        return w;
    endfunction

    function automatic screen_result_t res(input logic [2:0] vd, input logic fu,
                                           input logic rl, input logic [7:0] rt,
                                           input logic [7:0] rh, input logic [31:0] dr,
                                           input logic [31:0] rc);
        screen_result_t r;
        r = '{verdict: vd, for_us: fu, relay: rl, relay_ttl: rt, relay_hops: rh,
              dropped: dr, received: rc};
        return r;
    endfunction

    // Appends one row to the directed table.
    function automatic void add_row(input hdr_word_t w, input bit typed,
                                    input screen_result_t want);
        stim_row_t row;
        row.word = w;
        row.typed = typed;
        row.want = want;
        rows.insert(rows.size(), row);
    endfunction

    // The id goes into the next ring slot, duplicate or not.
    function automatic void remember_id(input logic [mfdf_pkg::ID_W-1:0] id);
        seen_ring[ring_slot] = id;
        ring_slot = (ring_slot + 1) % mfdf_pkg::CACHE_DEPTH_DEF;
    endfunction

    // Screens one header word against the shadow state and returns the result
    // the filter owes for it. The checks run in the block's order: version,
    // duplicate, authentication, replay.
    function automatic screen_result_t screen_header(input hdr_word_t w);
        screen_result_t r;
        bit             hit;
        r = '0;
        hit = 1'b0;
        foreach (seen_ring[k])
        begin
            if (seen_ring[k] == w.id)
                hit = 1'b1;
        end
        if (w.cmd)
        begin
            remember_id(w.id);
            r.verdict = mfdf_pkg::VERD_RECORDED;
        end
        else if (w.ver != want_version)
        begin
            drop_tally++;
            r.verdict = mfdf_pkg::VERD_BAD_VER;
        end
        else if (hit)
        begin
            // A duplicate is ignored outright: no total moves.
            r.verdict = mfdf_pkg::VERD_DUP;
        end
        else if (!w.auth)
        begin
            drop_tally++;
            r.verdict = mfdf_pkg::VERD_AUTH;
        end
        else if (!w.replay)
        begin
            drop_tally++;
            r.verdict = mfdf_pkg::VERD_REPLAY;
        end
        else
        begin
            remember_id(w.id);
            accept_tally++;
            r.verdict = mfdf_pkg::VERD_ACCEPT;
            r.for_us = (w.dest == node_mac) || (w.dest == mfdf_pkg::BCAST_ADDR);
            // Never echo our own packets, never relay on an exhausted budget, and
            // otherwise relay anything urgent or not meant for us alone.
            if (w.origin != node_mac && w.ttl > 8'd1 &&
                (w.mtype == urgent_type || w.dest == mfdf_pkg::BCAST_ADDR ||
                 w.dest != node_mac))
            begin
                r.relay = 1'b1;
                r.relay_ttl = w.ttl - 8'd1;
                r.relay_hops = w.hops + 8'd1;
            end
        end
        r.dropped = drop_tally;
        r.received = accept_tally;
        return r;
    endfunction

    // Writes one register while the filter is idle and mirrors it in the shadow.
    task automatic write_reg(input logic [mfdf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mfdf_pkg::CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            mfdf_pkg::REG_MY_MAC:     node_mac = data;
            mfdf_pkg::REG_PROTO_VER:  want_version = data[mfdf_pkg::BYTE_W-1:0];
            mfdf_pkg::REG_EMERG_TYPE: urgent_type = data[mfdf_pkg::BYTE_W-1:0];
            default:                  ;
        endcase
    endtask

    // Offers one word and returns at the edge that takes it, with start still
    // high so that a back-to-back word needs no second assignment in that step.
    // An idle burst is counted either from the last handshake, so that start
    // rises somewhere inside the busy window, or from the last result, so that
    // it rises some cycles after the filter has gone idle.
    task automatic send_word(input hdr_word_t w, input int gap, input bit typed,
                             input screen_result_t want);
        screen_result_t predicted;
        if (gap > 0)
        begin
            start <= 1'b0;
            if ($urandom_range(0, 1) == 1)
            begin
                while (pending_verdicts.size() != 0)
                    @(posedge clk);
            end
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        command <= w.cmd;
        version <= w.ver;
        message_id <= w.id;
        msg_type <= w.mtype;
        ttl <= w.ttl;
        hop_count <= w.hops;
        origin_mac <= w.origin;
        dest_mac <= w.dest;
        auth_ok <= w.auth;
        replay_ok <= w.replay;
        do
            @(posedge clk);
        while (busy);
        predicted = screen_header(w);
        pending_verdicts.insert(pending_verdicts.size(), typed ? want : predicted);
    endtask

    task automatic check_field(input string name, input logic [47:0] want_v,
                               input logic [47:0] got_v);
        if (got_v !== want_v)
        begin
            $error("%s: expected %0h, got %0h", name, want_v, got_v);
            fail_seen = 1'b1;
        end
    endtask

    // Every done pulse carries one result word; it is matched against the
    // oldest word still owed.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_verdicts.size() == 0)
            begin
                $error("result word with no screened word waiting for it");
                fail_seen = 1'b1;
            end
            else
            begin
                head_r = pending_verdicts.pop_front();
                check_field("verdict", 48'(head_r.verdict), 48'(verdict));
                check_field("for_us", 48'(head_r.for_us), 48'(for_us));
                check_field("relay", 48'(head_r.relay), 48'(relay));
                check_field("relay_ttl", 48'(head_r.relay_ttl), 48'(relay_ttl));
                check_field("relay_hops", 48'(head_r.relay_hops), 48'(relay_hops));
                check_field("dropped_total", 48'(head_r.dropped), 48'(dropped_total));
                check_field("received_total", 48'(head_r.received), 48'(received_total));
            end
        end
    end

    initial
    begin
        hdr_word_t                  w;
        screen_result_t             unused_r;
        int                         gap;
        int                         pick;
        bit                         idle_on;
        logic [63:0]                wide;
        logic [mfdf_pkg::MAC_W-1:0] mac_v;
        logic [7:0]                 ver_v;
        logic [7:0]                 urg_v;

        foreach (seen_ring[k])
            seen_ring[k] = '0;
        unused_r = '0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, run at the reset configuration: my address zero,
        // version one, urgent type zero, and a cache full of zero ids.
        // Id zero is already in the cleared cache.
        add_row(hdr(0, 1, 0, 0, 9, 0, 48'h1, 48'h2, 1, 1), 1'b1,
                res(mfdf_pkg::VERD_DUP, 0, 0, 0, 0, 0, 0));
        // Wrong versions at both ends of the byte.
        add_row(hdr(0, 0, 1, 0, 9, 0, 48'h1, 48'h2, 1, 1), 1'b1,
                res(mfdf_pkg::VERD_BAD_VER, 0, 0, 0, 0, 1, 0));
        add_row(hdr(0, 8'hFF, 2, 0, 9, 0, 48'h1, 48'h2, 1, 1), 1'b1,
                res(mfdf_pkg::VERD_BAD_VER, 0, 0, 0, 0, 2, 0));
        // Authentication failure, then replay failure.
        add_row(hdr(0, 1, 32'hFFFF_FFFF, 0, 9, 0, 48'h1, 48'h2, 0, 1), 1'b1,
                res(mfdf_pkg::VERD_AUTH, 0, 0, 0, 0, 3, 0));
        add_row(hdr(0, 1, 32'hFFFF_FFFF, 0, 9, 0, 48'h1, 48'h2, 1, 0), 1'b1,
                res(mfdf_pkg::VERD_REPLAY, 0, 0, 0, 0, 4, 0));
        // Accepted broadcast with id, ttl, hops and both addresses at their top; the hop count wraps.
        add_row(hdr(0, 1, 32'hFFFF_FFFF, 0, 8'hFF, 8'hFF, mfdf_pkg::BCAST_ADDR,
                    mfdf_pkg::BCAST_ADDR, 1, 1), 1'b1,
                res(mfdf_pkg::VERD_ACCEPT, 1, 1, 8'hFE, 8'h00, 4, 1));
        // The same id again is a duplicate.
        add_row(hdr(0, 1, 32'hFFFF_FFFF, 0, 9, 0, 48'h1, 48'h2, 1, 1), 1'b1,
                res(mfdf_pkg::VERD_DUP, 0, 0, 0, 0, 4, 1));
        // Version is checked before the cache, the cache before authentication.
        add_row(hdr(0, 2, 32'hFFFF_FFFF, 8'hFF, 9, 0, 48'h1, 48'h2, 1, 1), 1'b1,
                res(mfdf_pkg::VERD_BAD_VER, 0, 0, 0, 0, 5, 1));
        add_row(hdr(0, 1, 32'hFFFF_FFFF, 0, 9, 0, 48'h1, 48'h2, 0, 0), 1'b1,
                res(mfdf_pkg::VERD_DUP, 0, 0, 0, 0, 5, 1));
        // A locally sent id is recorded whatever the other fields say.
        add_row(hdr(1, 0, 32'h1234_5678, 0, 0, 0, 48'h0, 48'h0, 0, 0), 1'b1,
                res(mfdf_pkg::VERD_RECORDED, 0, 0, 0, 0, 5, 1));
        add_row(hdr(0, 1, 32'h1234_5678, 0, 9, 0, 48'h1, 48'h2, 1, 1), 1'b1,
                res(mfdf_pkg::VERD_DUP, 0, 0, 0, 0, 5, 1));
        add_row(hdr(1, 0, 32'h1234_5678, 0, 0, 0, 48'h0, 48'h0, 0, 0), 1'b1,
                res(mfdf_pkg::VERD_RECORDED, 0, 0, 0, 0, 5, 1));
        // Relay decisions: unicast to us, urgent unicast to us, our own origin,
        // ttl of one and zero, smallest relayable ttl to someone else.
        add_row(hdr(0, 1, 1, 7, 5, 3, 48'h5, 48'h0, 1, 1), 1'b0, unused_r);
        add_row(hdr(0, 1, 2, 0, 5, 3, 48'h5, 48'h0, 1, 1), 1'b0, unused_r);
        add_row(hdr(0, 1, 3, 0, 9, 3, 48'h0, mfdf_pkg::BCAST_ADDR, 1, 1), 1'b0, unused_r);
        add_row(hdr(0, 1, 4, 0, 1, 3, 48'h5, 48'h123, 1, 1), 1'b0, unused_r);
        add_row(hdr(0, 1, 5, 0, 0, 3, 48'h5, 48'h123, 1, 1), 1'b0, unused_r);
        add_row(hdr(0, 1, 6, 8'h80, 2, 0, 48'h1, 48'hAB_CDEF, 1, 1), 1'b0, unused_r);
        add_row(hdr(1, 8'hFF, 0, 8'hFF, 8'hFF, 8'hFF, mfdf_pkg::BCAST_ADDR,
                    mfdf_pkg::BCAST_ADDR, 1, 1), 1'b0, unused_r);
        add_row(hdr(0, 1, 0, 0, 9, 0, 48'h1, 48'h2, 1, 1), 1'b0, unused_r);

        foreach (rows[i])
        begin
            gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 13) : 0;
            send_word(rows[i].word, gap, rows[i].typed, rows[i].want);
        end

        // Random part in eight stages, each with its own configuration. The
        // fourth and the last stage run with start held high throughout.
        for (int stage = 0; stage < 8; stage++)
        begin
            // Let the filter finish before touching its registers.
            start <= 1'b0;
            while (pending_verdicts.size() != 0)
                @(posedge clk);
            repeat (40) @(posedge clk);

            wide = {$urandom, $urandom};
            mac_v = wide[47:0];
            ver_v = 8'($urandom);
            urg_v = 8'($urandom);
            case (stage)
                1:
                begin
                    mac_v = '0;
                    ver_v = '0;
                    urg_v = '0;
                end
                2:
                begin
                    // Our own address equals the broadcast address here.
                    mac_v = mfdf_pkg::BCAST_ADDR;
                    ver_v = 8'hFF;
                    urg_v = 8'hFF;
                end
                4:
                    ver_v = mfdf_pkg::PROTO_VER_RST;
                default:
                    ;
            endcase
            // The byte registers get junk in the upper bits of the write data.
            write_reg(mfdf_pkg::REG_MY_MAC, mac_v);
            wide = {$urandom, $urandom};
            write_reg(mfdf_pkg::REG_PROTO_VER, {wide[47:8], ver_v});
            wide = {$urandom, $urandom};
            write_reg(mfdf_pkg::REG_EMERG_TYPE, {wide[47:8], urg_v});
            wide = {$urandom, $urandom};
            write_reg(REG_SPARE, wide[47:0]);

            idle_on = (stage != 3) && (stage != 7);
            for (int n = 0; n < 180; n++)
            begin
                // Mostly well-formed packets that pass the version check, with
                // ids drawn often from the recent ones so that duplicates and
                // the zero id come up regularly.
                w.cmd = ($urandom_range(0, 7) == 0);
                if ($urandom_range(0, 19) < 17)
                    w.ver = want_version;
                else
                    w.ver = 8'($urandom);
                pick = $urandom_range(0, 9);
                if (pick < 4 && recent_ids.size() > 0)
                    w.id = recent_ids[$urandom_range(0, recent_ids.size() - 1)];
                else if (pick == 4)
                    w.id = '0;
                else
                    w.id = $urandom;
                if ($urandom_range(0, 3) == 0)
                    w.mtype = urgent_type;
                else
                    w.mtype = 8'($urandom);
                if ($urandom_range(0, 3) == 0)
                    w.ttl = 8'($urandom_range(0, 2));
                else
                    w.ttl = 8'($urandom);
                w.hops = 8'($urandom);
                wide = {$urandom, $urandom};
                if ($urandom_range(0, 4) == 0)
                    w.origin = node_mac;
                else
                    w.origin = wide[47:0];
                wide = {$urandom, $urandom};
                pick = $urandom_range(0, 9);
                if (pick < 3)
                    w.dest = node_mac;
                else if (pick < 6)
                    w.dest = mfdf_pkg::BCAST_ADDR;
                else
                    w.dest = wide[47:0];
                w.auth = ($urandom_range(0, 9) != 0);
                w.replay = ($urandom_range(0, 9) != 0);

                recent_ids.insert(recent_ids.size(), w.id);
                if (recent_ids.size() > 48)
                    void'(recent_ids.pop_front());

                gap = (idle_on && $urandom_range(0, 2) == 0) ? $urandom_range(1, 13) : 0;
                send_word(w, gap, 1'b0, unused_r);
            end
        end

        // Drain, then give a stray result a couple of scan windows to show up.
        start <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (2 * mfdf_pkg::CACHE_DEPTH_DEF + 8) @(posedge clk);
        if (!fail_seen)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog: the slowest correct run needs about an eighth of this.
    initial
    begin
        #6000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
